/* src/gpio_ei_pkg.sv */
// Shared types and constants for the GPIO port with edge interrupts.
package gpio_ei_pkg;

  parameter int DATA_W        = 32;
  parameter int HALF_PINS     = 16;
  parameter int PIN_COUNT_DEF = 32;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    REG_DATA      = 3'd0,
    REG_DIRECTION = 3'd1,
    REG_PIN_STAT  = 3'd2,
    REG_COND_LOW  = 3'd3,
    REG_COND_HIGH = 3'd4,
    REG_MASK      = 3'd5,
    REG_STATUS    = 3'd6,
    REG_ANY_EDGE  = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    COND_LEVEL_LOW  = 2'd0,
    COND_LEVEL_HIGH = 2'd1,
    COND_RISING     = 2'd2,
    COND_FALLING    = 2'd3
  } cond_t;

  typedef struct packed {
    logic [DATA_W-1:0] levels;
    logic [DATA_W-1:0] last_levels;
    logic [DATA_W-1:0] any_edge;
    logic [DATA_W-1:0] cond_low;
    logic [DATA_W-1:0] cond_high;
  } detect_in_t;

endpackage

/* src/gpio_ei_detect.sv */
// Per-pin interrupt condition detection for one pin sample.
module gpio_ei_detect #(
  parameter int PIN_COUNT = gpio_ei_pkg::PIN_COUNT_DEF
) (
  input  gpio_ei_pkg::detect_in_t           det_in,
  output logic [gpio_ei_pkg::DATA_W-1:0]    hits
);
  import gpio_ei_pkg::*;

  for (genvar p = 0; p < DATA_W; p++) begin : g_pin
    if (p < PIN_COUNT) begin : g_live
      localparam int Lsb = 2 * (p % HALF_PINS);
      logic [1:0] code;
      logic       cur;
      logic       prev;
      logic       cond_hit;

      assign code = (p < HALF_PINS) ? det_in.cond_low[Lsb +: 2]
                                    : det_in.cond_high[Lsb +: 2];
      assign cur  = det_in.levels[p];
      assign prev = det_in.last_levels[p];

      always_comb begin
        case (cond_t'(code))
          COND_LEVEL_LOW:  cond_hit = !cur;
          COND_LEVEL_HIGH: cond_hit = cur;
          COND_RISING:     cond_hit = !prev && cur;
          COND_FALLING:    cond_hit = prev && !cur;
          default:         cond_hit = 1'b0;
        endcase
      end

      // any-edge select overrides the condition code
      assign hits[p] = det_in.any_edge[p] ? (cur ^ prev) : cond_hit;
    end else begin : g_dead
      assign hits[p] = 1'b0;
    end
  end

endmodule

/* src/gpio_port_with_edge_interrupts_unit.sv */
// Top level: GPIO port registers, interrupt status and the beat pipeline.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  in_      | input     | in_valid/in_stall | req_type, reg_index, write_data, pin_levels
//  out_     | output    | out_valid/out_stall | read_data, pins_driven, pins_enabled, irq
//
//  One beat accepted per cycle while in_stall is low; each beat passes through
//  the input register, then the result register, loaded from the single-pass update.
//  Reset (rst_n low, synchronous) clears all port registers and both stages.
//  While out_stall holds a result, the input register still takes one beat;
//  in_stall rises only when both stages are full and the result is held.
module gpio_port_with_edge_interrupts_unit #(
  parameter int PIN_COUNT = gpio_ei_pkg::PIN_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic [2:0]                        in_reg_index,
  input  logic [gpio_ei_pkg::DATA_W-1:0]    in_write_data,
  input  logic [gpio_ei_pkg::DATA_W-1:0]    in_pin_levels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gpio_ei_pkg::DATA_W-1:0]    out_read_data,
  output logic [gpio_ei_pkg::DATA_W-1:0]    out_pins_driven,
  output logic [gpio_ei_pkg::DATA_W-1:0]    out_pins_enabled,
  output logic                              out_irq_line
);
  import gpio_ei_pkg::*;

  localparam logic [DATA_W-1:0] PinMask = DATA_W'((65'd1 << PIN_COUNT) - 65'd1);

  // input register
  logic              s1_valid_r;
  logic [1:0]        s1_req_type_r;
  logic [2:0]        s1_reg_index_r;
  logic [DATA_W-1:0] s1_write_data_r;
  logic [DATA_W-1:0] s1_pin_levels_r;

  // port state
  logic [DATA_W-1:0] data_r,      data_nxt;
  logic [DATA_W-1:0] dir_r,       dir_nxt;
  logic [DATA_W-1:0] cond_low_r,  cond_low_nxt;
  logic [DATA_W-1:0] cond_high_r, cond_high_nxt;
  logic [DATA_W-1:0] mask_r,      mask_nxt;
  logic [DATA_W-1:0] status_r,    status_nxt;
  logic [DATA_W-1:0] any_edge_r,  any_edge_nxt;
  logic [DATA_W-1:0] last_r,      last_nxt;

  // result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_data_r;
  logic [DATA_W-1:0] out_pins_driven_r;
  logic [DATA_W-1:0] out_pins_enabled_r;
  logic              out_irq_line_r;

  logic              advance;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] levels;
  logic [DATA_W-1:0] hits;
  detect_in_t        det_in;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign levels   = s1_pin_levels_r & PinMask;

  assign det_in.levels      = levels;
  assign det_in.last_levels = last_r;
  assign det_in.any_edge    = any_edge_r;
  assign det_in.cond_low    = cond_low_r;
  assign det_in.cond_high   = cond_high_r;

  gpio_ei_detect #(
    .PIN_COUNT (PIN_COUNT)
  ) u_detect (
    .det_in (det_in),
    .hits   (hits)
  );

  always_comb begin
    data_nxt      = data_r;
    dir_nxt       = dir_r;
    cond_low_nxt  = cond_low_r;
    cond_high_nxt = cond_high_r;
    mask_nxt      = mask_r;
    status_nxt    = status_r;
    any_edge_nxt  = any_edge_r;
    last_nxt      = last_r;
    rdata         = '0;
    case (req_type_t'(s1_req_type_r))
      REQ_READ: begin
        case (reg_index_t'(s1_reg_index_r))
          REG_DATA:      rdata = data_r;
          REG_DIRECTION: rdata = dir_r;
          REG_PIN_STAT:  rdata = last_r;
          REG_COND_LOW:  rdata = cond_low_r;
          REG_COND_HIGH: rdata = cond_high_r;
          REG_MASK:      rdata = mask_r;
          REG_STATUS:    rdata = status_r;
          REG_ANY_EDGE:  rdata = any_edge_r;
          default:       rdata = '0;
        endcase
      end
      REQ_WRITE: begin
        case (reg_index_t'(s1_reg_index_r))
          REG_DATA:      data_nxt      = s1_write_data_r & PinMask;
          REG_DIRECTION: dir_nxt       = s1_write_data_r & PinMask;
          REG_PIN_STAT:  ;
          REG_COND_LOW:  cond_low_nxt  = s1_write_data_r;
          REG_COND_HIGH: cond_high_nxt = s1_write_data_r;
          REG_MASK:      mask_nxt      = s1_write_data_r & PinMask;
          // write one to clear
          REG_STATUS:    status_nxt    = status_r & ~s1_write_data_r;
          REG_ANY_EDGE:  any_edge_nxt  = s1_write_data_r & PinMask;
          default:       ;
        endcase
      end
      REQ_TICK: begin
        status_nxt = status_r | (hits & PinMask);
        last_nxt   = levels;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_req_type_r   <= in_req_type;
      s1_reg_index_r  <= in_reg_index;
      s1_write_data_r <= in_write_data;
      s1_pin_levels_r <= in_pin_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r      <= '0;
      dir_r       <= '0;
      cond_low_r  <= '0;
      cond_high_r <= '0;
      mask_r      <= '0;
      status_r    <= '0;
      any_edge_r  <= '0;
      last_r      <= '0;
    end else if (advance) begin
      data_r      <= data_nxt;
      dir_r       <= dir_nxt;
      cond_low_r  <= cond_low_nxt;
      cond_high_r <= cond_high_nxt;
      mask_r      <= mask_nxt;
      status_r    <= status_nxt;
      any_edge_r  <= any_edge_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // results show the state after the beat has taken effect
  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data_r    <= rdata;
      out_pins_driven_r  <= data_nxt & dir_nxt;
      out_pins_enabled_r <= dir_nxt;
      out_irq_line_r     <= |(status_nxt & mask_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_pins_driven  = out_pins_driven_r;
  assign out_pins_enabled = out_pins_enabled_r;
  assign out_irq_line     = out_irq_line_r;

  a_result_tracks_state : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pins_enabled_r == dir_r) &&
                    (out_irq_line_r == |(status_r & mask_r)))
    else $error("result register out of step with port state");

  a_no_status_above_pins : assert property (@(posedge clk) disable iff (!rst_n)
    ((status_r | last_r | mask_r) & ~PinMask) == '0)
    else $error("state bit set above PIN_COUNT");

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with a free stage");

  a_state_holds_without_beat : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(status_r) && $stable(last_r) && $stable(dir_r))
    else $error("port state changed without a beat");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the GPIO port with edge interrupts: directed and random beats.
module tb_top;
  import gpio_ei_pkg::*;

  localparam int PINS = PIN_COUNT_DEF;
  localparam logic [DATA_W-1:0] PIN_MASK = {DATA_W{1'b1}} >> (DATA_W - PINS);
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_GAP = 12;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 250000;
  localparam int RANDOM_BEATS = 900;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pins_driven;
    logic [DATA_W-1:0] pins_enabled;
    logic              irq_line;
  } port_view_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_req_type;
  logic [2:0]        in_reg_index;
  logic [DATA_W-1:0] in_write_data;
  logic [DATA_W-1:0] in_pin_levels;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_read_data;
  logic [DATA_W-1:0] out_pins_driven;
  logic [DATA_W-1:0] out_pins_enabled;
  logic              out_irq_line;

  // Port state as the block should hold it
  logic [DATA_W-1:0] port_data     = '0;
  logic [DATA_W-1:0] port_dir      = '0;
  logic [DATA_W-1:0] port_cond_lo  = '0;
  logic [DATA_W-1:0] port_cond_hi  = '0;
  logic [DATA_W-1:0] port_mask     = '0;
  logic [DATA_W-1:0] port_status   = '0;
  logic [DATA_W-1:0] port_any_edge = '0;
  logic [DATA_W-1:0] port_last_lv  = '0;

  port_view_t        expected_views[$];
  int                fail_count = 0;
  int                cycle_count = 0;
  bit                steady_in = 1'b0;
  bit                steady_out = 1'b0;
  logic [DATA_W-1:0] pins_now = '0;

  gpio_port_with_edge_interrupts_unit #(
    .PIN_COUNT(PINS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_reg_index(in_reg_index),
    .in_write_data(in_write_data),
    .in_pin_levels(in_pin_levels),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_data(out_read_data),
    .out_pins_driven(out_pins_driven),
    .out_pins_enabled(out_pins_enabled),
    .out_irq_line(out_irq_line)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] pin_hits(input logic [DATA_W-1:0] now);
    logic [DATA_W-1:0] hits;
    logic              cur;
    logic              prev;
    logic [1:0]        code;
    hits = '0;
    for (int p = 0; p < PINS; p++) begin
      cur = now[p];
      prev = port_last_lv[p];
      // any-edge select overrides the condition code
      if (port_any_edge[p]) begin
        hits[p] = cur != prev;
      end else begin
        code = (p < HALF_PINS) ? port_cond_lo[2*p +: 2] : port_cond_hi[2*(p-HALF_PINS) +: 2];
        case (cond_t'(code))
          COND_LEVEL_LOW:  hits[p] = !cur;
          COND_LEVEL_HIGH: hits[p] = cur;
          COND_RISING:     hits[p] = !prev && cur;
          default:         hits[p] = prev && !cur;
        endcase
      end
    end
    return hits;
  endfunction

  function automatic port_view_t apply_access(input logic [1:0] kind, input logic [2:0] idx,
                                              input logic [DATA_W-1:0] wdata,
                                              input logic [DATA_W-1:0] levels);
    port_view_t v;
    v = '0;
    case (kind)
      REQ_READ: begin
        case (idx)
          REG_DATA:      v.read_data = port_data;
          REG_DIRECTION: v.read_data = port_dir;
          REG_PIN_STAT:  v.read_data = port_last_lv;
          REG_COND_LOW:  v.read_data = port_cond_lo;
          REG_COND_HIGH: v.read_data = port_cond_hi;
          REG_MASK:      v.read_data = port_mask;
          REG_STATUS:    v.read_data = port_status;
          default:       v.read_data = port_any_edge;
        endcase
      end
      REQ_WRITE: begin
        case (idx)
          REG_DATA:      port_data = wdata & PIN_MASK;
          REG_DIRECTION: port_dir = wdata & PIN_MASK;
          REG_PIN_STAT:  ;
          REG_COND_LOW:  port_cond_lo = wdata;
          REG_COND_HIGH: port_cond_hi = wdata;
          REG_MASK:      port_mask = wdata & PIN_MASK;
          REG_STATUS:    port_status = port_status & ~wdata;
          default:       port_any_edge = wdata & PIN_MASK;
        endcase
      end
      REQ_TICK: begin
        port_status = port_status | (pin_hits(levels & PIN_MASK) & PIN_MASK);
        port_last_lv = levels & PIN_MASK;
      end
      default: ;
    endcase
    v.pins_driven = port_data & port_dir;
    v.pins_enabled = port_dir;
    v.irq_line = |(port_status & port_mask);
    return v;
  endfunction

  // Predict on every accepted input beat, check every accepted result beat
  always @(posedge clk) begin : port_monitor
    port_view_t want;
    port_view_t got;
    bit         bad;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_views.push_back(apply_access(in_req_type, in_reg_index, in_write_data,
                                              in_pin_levels));
      if (out_valid && !out_stall) begin
        got = '{out_read_data, out_pins_driven, out_pins_enabled, out_irq_line};
        if (expected_views.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result beat with nothing expected: read %h driven %h enabled %h irq %b",
                     got.read_data, got.pins_driven, got.pins_enabled, got.irq_line);
        end else begin
          want = expected_views.pop_front();
          bad = (got.read_data !== want.read_data) || (got.pins_driven !== want.pins_driven) ||
                (got.pins_enabled !== want.pins_enabled) || (got.irq_line !== want.irq_line);
          if (bad) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch (exp/got): read %h/%h driven %h/%h enabled %h/%h irq %b/%b",
                       want.read_data, got.read_data, want.pins_driven, got.pins_driven,
                       want.pins_enabled, got.pins_enabled, want.irq_line, got.irq_line);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: raise out_stall for a random gap before each beat, or not at all while steady_out is set
  initial begin : result_stall
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = steady_out ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic send_access(input logic [1:0] kind, input logic [2:0] idx,
                             input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] levels);
    int unsigned gap;
    gap = steady_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_reg_index <= idx;
    in_write_data <= wdata;
    in_pin_levels <= levels;
    do @(posedge clk); while (in_stall);
    if (kind == REQ_TICK)
      pins_now = levels & PIN_MASK;
  endtask

  // Hold off the sender until every predicted beat has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_values();
    for (int r = 0; r < 8; r++)
      send_access(REQ_READ, 3'(r), '1, '1);
  endtask

  task automatic test_first_tick_rising();
    send_access(REQ_WRITE, REG_MASK, '1, '0);
    send_access(REQ_WRITE, REG_COND_LOW, 32'hAAAA_AAAA, '0);
    send_access(REQ_WRITE, REG_COND_HIGH, 32'hAAAA_AAAA, '0);
    // previous level is the reset zero, so every high pin counts as rising
    send_access(REQ_TICK, REG_DATA, '0, '1);
    send_access(REQ_WRITE, REG_STATUS, '1, '0);
    send_access(REQ_WRITE, REG_PIN_STAT, 32'h1234_5678, '0);
    send_access(REQ_READ, REG_PIN_STAT, '0, '0);
  endtask

  task automatic test_level_retrigger();
    send_access(REQ_WRITE, REG_COND_LOW, '0, '0);
    send_access(REQ_TICK, REG_DATA, '0, 32'hFFFF_0000);
    send_access(REQ_WRITE, REG_STATUS, 32'h0000_FFFF, '0);
    // level still low: status comes straight back after the clear
    send_access(REQ_TICK, REG_DATA, '0, 32'hFFFF_0000);
  endtask

  task automatic test_any_edge_and_outputs();
    send_access(REQ_WRITE, REG_ANY_EDGE, '1, '0);
    send_access(REQ_TICK, REG_ANY_EDGE, '1, 32'h0000_FFFF);
    send_access(REQ_WRITE, REG_DATA, '1, '0);
    send_access(REQ_WRITE, REG_DIRECTION, '1, '0);
    send_access(REQ_UNUSED, REG_ANY_EDGE, '1, '1);
    send_access(REQ_READ, REG_STATUS, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int beats);
    int unsigned       pick;
    logic [1:0]        kind;
    logic [DATA_W-1:0] levels;
    for (int i = 0; i < beats; i++) begin
      if (i % 100 == 0) begin
        steady_in = $urandom_range(0, 3) == 0;
        steady_out = $urandom_range(0, 3) == 0;
      end
      if (i == beats / 2)
        wait_drained();
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? REQ_TICK : (pick < 70) ? REQ_WRITE : (pick < 97) ? REQ_READ
                                                                              : REQ_UNUSED;
      // mostly sparse pin changes so edges stay distinct from levels
      case ($urandom_range(0, 3))
        0:       levels = $urandom;
        3:       levels = pins_now;
        default: levels = pins_now ^ ($urandom & $urandom & $urandom);
      endcase
      send_access(kind, 3'($urandom_range(0, 7)), pick_word(), levels);
    end
    steady_in = 1'b0;
    steady_out = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_READ;
    in_reg_index = REG_DATA;
    in_write_data = '0;
    in_pin_levels = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_first_tick_rising();
    test_level_retrigger();
    test_any_edge_and_outputs();
    test_random_traffic(RANDOM_BEATS);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
src/gpio_ei_pkg.sv
src/gpio_ei_detect.sv
src/gpio_port_with_edge_interrupts_unit.sv
tb/sv/tb_top.sv
